// File: src/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, constants and control records of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int ID_WIDTH     = 8;
    localparam int TIME_W       = 48;
    localparam int DELAY_W      = 32;
    localparam int MARGIN_W     = 32;
    localparam int REQ_W        = 2;
    localparam int PRIO_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int PEND_W       = 7;

    localparam int NUM_PRIORITIES_DEF = 4;
    localparam int FIFO_DEPTH_DEF     = 16;
    localparam int DEFERRED_DEPTH_DEF = 8;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 32'd500;
    localparam logic [TIME_W-1:0]   TIME_SIGN    = 48'h8000_0000_0000;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_SUBMIT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEFER  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_NEXT   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]    req_type;
        logic [ID_WIDTH-1:0] task_id;
        logic [PRIO_W-1:0]   priority_req;
        logic [TIME_W-1:0]   now;
        logic [DELAY_W-1:0]  delay;
    } in_item_t;

    typedef struct packed {
        logic                granted;
        logic [ID_WIDTH-1:0] grant_id;
        logic                from_deferred;
        logic [STATUS_W-1:0] status;
        logic [PEND_W-1:0]   pending_count;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic submit;
        logic scan_start;
        logic decide;
        logic fifo_take;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic fifo_pop;
        logic out_free;
    } stat_t;

endpackage

// File: src/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/pts_ctrl.sv
// ----------------------------------------------------------------------------
// pts_ctrl
// Sequencer that steps one transaction through the scheduler datapath.
// ----------------------------------------------------------------------------
module pts_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pts_pkg::REQ_W-1:0]    req_type,
    output pts_pkg::cmd_t                cmd,
    input  pts_pkg::stat_t               stat
);
    import pts_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SUBMIT  = 6'b000010,
        S_SCAN    = 6'b000100,
        S_DECIDE  = 6'b001000,
        S_FIFO_RD = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    case (req_type)
                        REQ_SUBMIT: state_next = S_SUBMIT;
                        REQ_DEFER, REQ_NEXT:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        default: state_next = S_EMIT;
                    endcase
                end
            end
            S_SUBMIT:
            begin
                cmd.submit = 1'b1;
                state_next = S_EMIT;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.fifo_pop ? S_FIFO_RD : S_EMIT;
            end
            S_FIFO_RD:
            begin
                cmd.fifo_take = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// File: src/pts_dp.sv
// ----------------------------------------------------------------------------
// pts_dp
// Scheduler datapath: priority FIFOs, deferred list scan and result register.
// ----------------------------------------------------------------------------
module pts_dp #(
    parameter int NUM_PRIORITIES = pts_pkg::NUM_PRIORITIES_DEF,
    parameter int FIFO_DEPTH     = pts_pkg::FIFO_DEPTH_DEF,
    parameter int DEFERRED_DEPTH = pts_pkg::DEFERRED_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pts_pkg::in_item_t             in_item,
    input  logic                          cfg_we,
    input  logic [pts_pkg::MARGIN_W-1:0]  cfg_wdata,
    input  pts_pkg::cmd_t                 cmd,
    output pts_pkg::stat_t                stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pts_pkg::out_item_t            out_item
);
    import pts_pkg::*;

    localparam int PW   = $clog2(NUM_PRIORITIES);
    localparam int FAW  = $clog2(FIFO_DEPTH);
    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam int FRD  = NUM_PRIORITIES * FIFO_DEPTH;
    localparam int RAW  = $clog2(FRD);
    localparam int TOTW = $clog2(FRD + 1);
    localparam int DAW  = (DEFERRED_DEPTH > 1) ? $clog2(DEFERRED_DEPTH) : 1;
    localparam int ICW  = $clog2(DEFERRED_DEPTH + 1);
    localparam int DW   = ID_WIDTH + TIME_W;

    // Latched transaction.
    logic [REQ_W-1:0]    req_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [PW-1:0]       prio_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [DELAY_W-1:0]  delay_reg;
    logic [PW-1:0]       prio_sat;

    logic [MARGIN_W-1:0] margin_reg;

    // FIFO bookkeeping.
    logic [FAW-1:0]  head_reg [NUM_PRIORITIES];
    logic [FAW-1:0]  head_next [NUM_PRIORITIES];
    logic [CW-1:0]   cnt_reg  [NUM_PRIORITIES];
    logic [CW-1:0]   cnt_next [NUM_PRIORITIES];
    logic [TOTW-1:0] total_reg, total_next;
    logic [PW-1:0]   popq_reg, popq_next;

    // Deferred list bookkeeping.
    logic [DEFERRED_DEPTH-1:0] valid_reg, valid_next;
    logic [DAW-1:0]  age_reg  [DEFERRED_DEPTH];
    logic [DAW-1:0]  age_next [DEFERRED_DEPTH];

    // Scan state.
    logic            scan_act_reg, scan_act_next;
    logic [ICW-1:0]  issue_reg, issue_next;
    logic            rd_vld_reg, rd_vld_next;
    logic [DAW-1:0]  rd_idx_reg, rd_idx_next;
    logic            done_reg, done_next;
    logic            best_fnd_reg, best_fnd_next;
    logic [DAW-1:0]  best_idx_reg, best_idx_next;
    logic [TIME_W-1:0] best_diff_reg, best_diff_next;
    logic [DAW-1:0]  best_age_reg, best_age_next;
    logic [ID_WIDTH-1:0] best_id_reg, best_id_next;
    logic            free_fnd_reg, free_fnd_next;
    logic [DAW-1:0]  free_idx_reg, free_idx_next;

    // Result being assembled and output stage.
    logic                res_gnt_reg, res_gnt_next;
    logic [ID_WIDTH-1:0] res_id_reg, res_id_next;
    logic                res_def_reg, res_def_next;
    logic [STATUS_W-1:0] res_st_reg, res_st_next;
    logic                ov_reg, ov_next;
    out_item_t           oitem_reg, oitem_next;

    // Memory ports.
    logic                fifo_we;
    logic [RAW-1:0]      fifo_waddr, fifo_raddr;
    logic [ID_WIDTH-1:0] fifo_rdata;
    logic                def_we;
    logic [DW-1:0]       def_wdata, def_rdata;
    logic [DAW-1:0]      def_raddr;

    // Combinational helpers.
    logic [CW:0]         slot_sum;
    logic [FAW-1:0]      slot;
    logic [TIME_W-1:0]   diff;
    logic                better;
    logic                release_def;
    logic                q_fnd;
    logic [PW-1:0]       q_sel;

    pts_ram #(.WIDTH(ID_WIDTH), .DEPTH(FRD)) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (id_reg),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    pts_ram #(.WIDTH(DW), .DEPTH(DEFERRED_DEPTH)) u_def_ram (
        .clk   (clk),
        .we    (def_we),
        .waddr (free_idx_reg),
        .wdata (def_wdata),
        .raddr (def_raddr),
        .rdata (def_rdata)
    );

    always_comb
    begin
        if (32'(in_item.priority_req) >= NUM_PRIORITIES)
        begin
            prio_sat = PW'(NUM_PRIORITIES - 1);
        end
        else
        begin
            prio_sat = PW'(in_item.priority_req);
        end
    end

    // Tail slot of the selected FIFO, wrapped once.
    always_comb
    begin
        slot_sum = (CW+1)'(head_reg[prio_reg]) + (CW+1)'(cnt_reg[prio_reg]);
        if (slot_sum >= (CW+1)'(FIFO_DEPTH))
        begin
            slot = FAW'(slot_sum - (CW+1)'(FIFO_DEPTH));
        end
        else
        begin
            slot = FAW'(slot_sum);
        end
    end

    // Highest non-empty priority level.
    always_comb
    begin
        q_fnd = 1'b0;
        q_sel = '0;
        for (int p = 0; p < NUM_PRIORITIES; p++)
        begin
            if (cnt_reg[p] != '0)
            begin
                q_fnd = 1'b1;
                q_sel = PW'(p);
            end
        end
    end

    assign fifo_waddr = RAW'(32'(prio_reg) * FIFO_DEPTH + 32'(slot));
    assign fifo_raddr = RAW'(32'(q_sel) * FIFO_DEPTH + 32'(head_reg[q_sel]));
    assign def_raddr  = issue_reg[DAW-1:0];
    assign def_wdata  = {id_reg, now_reg + TIME_W'(delay_reg)};

    assign diff   = def_rdata[TIME_W-1:0] - now_reg;
    assign better = !best_fnd_reg
                 || ((diff ^ TIME_SIGN) < (best_diff_reg ^ TIME_SIGN))
                 || ((diff == best_diff_reg) && (age_reg[rd_idx_reg] > best_age_reg));

    assign release_def = best_fnd_reg
                      && (best_diff_reg[TIME_W-1] || (best_diff_reg <= TIME_W'(margin_reg)));

    assign stat.scan_done = done_reg;
    assign stat.fifo_pop  = (req_reg == REQ_NEXT) && !release_def && q_fnd;
    assign stat.out_free  = !ov_reg || out_ready;

    assign out_valid = ov_reg;
    assign out_item  = oitem_reg;

    always_comb
    begin
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        popq_next      = popq_reg;
        valid_next     = valid_reg;
        age_next       = age_reg;
        scan_act_next  = scan_act_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        done_next      = done_reg;
        best_fnd_next  = best_fnd_reg;
        best_idx_next  = best_idx_reg;
        best_diff_next = best_diff_reg;
        best_age_next  = best_age_reg;
        best_id_next   = best_id_reg;
        free_fnd_next  = free_fnd_reg;
        free_idx_next  = free_idx_reg;
        res_gnt_next   = res_gnt_reg;
        res_id_next    = res_id_reg;
        res_def_next   = res_def_reg;
        res_st_next    = res_st_reg;
        ov_next        = ov_reg && !out_ready;
        oitem_next     = oitem_reg;
        fifo_we        = 1'b0;
        def_we         = 1'b0;

        if (cmd.load_item)
        begin
            res_gnt_next = 1'b0;
            res_id_next  = '0;
            res_def_next = 1'b0;
            res_st_next  = ST_OK;
        end

        if (cmd.scan_start)
        begin
            scan_act_next = 1'b1;
            issue_next    = '0;
            done_next     = 1'b0;
            best_fnd_next = 1'b0;
            free_fnd_next = 1'b0;
        end

        // Issue one deferred entry read per cycle.
        if (scan_act_reg)
        begin
            rd_vld_next = 1'b1;
            rd_idx_next = issue_reg[DAW-1:0];
            issue_next  = issue_reg + 1'b1;
            if (issue_reg == ICW'(DEFERRED_DEPTH - 1))
            begin
                scan_act_next = 1'b0;
            end
        end

        // Evaluate the entry whose data just came back.
        if (rd_vld_reg)
        begin
            if (valid_reg[rd_idx_reg])
            begin
                if (better)
                begin
                    best_fnd_next  = 1'b1;
                    best_idx_next  = rd_idx_reg;
                    best_diff_next = diff;
                    best_age_next  = age_reg[rd_idx_reg];
                    best_id_next   = def_rdata[DW-1:TIME_W];
                end
            end
            else if (!free_fnd_reg)
            begin
                free_fnd_next = 1'b1;
                free_idx_next = rd_idx_reg;
            end
            if (rd_idx_reg == DAW'(DEFERRED_DEPTH - 1))
            begin
                done_next = 1'b1;
            end
        end

        if (cmd.submit)
        begin
            if (cnt_reg[prio_reg] == CW'(FIFO_DEPTH))
            begin
                res_st_next = ST_FULL;
            end
            else
            begin
                fifo_we            = 1'b1;
                cnt_next[prio_reg] = cnt_reg[prio_reg] + 1'b1;
                total_next         = total_reg + 1'b1;
            end
        end

        if (cmd.decide)
        begin
            if (req_reg == REQ_DEFER)
            begin
                if (free_fnd_reg)
                begin
                    def_we = 1'b1;
                    for (int i = 0; i < DEFERRED_DEPTH; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            age_next[i] = age_reg[i] + 1'b1;
                        end
                    end
                    age_next[free_idx_reg]   = '0;
                    valid_next[free_idx_reg] = 1'b1;
                end
                else
                begin
                    res_st_next = ST_FULL;
                end
            end
            else if (release_def)
            begin
                res_gnt_next = 1'b1;
                res_id_next  = best_id_reg;
                res_def_next = 1'b1;
                for (int i = 0; i < DEFERRED_DEPTH; i++)
                begin
                    if (valid_reg[i] && (age_reg[i] > best_age_reg))
                    begin
                        age_next[i] = age_reg[i] - 1'b1;
                    end
                end
                valid_next[best_idx_reg] = 1'b0;
                age_next[best_idx_reg]   = '0;
            end
            else if (q_fnd)
            begin
                popq_next = q_sel;
            end
            else
            begin
                res_st_next = ST_NONE;
            end
        end

        if (cmd.fifo_take)
        begin
            res_gnt_next = 1'b1;
            res_id_next  = fifo_rdata;
            if (head_reg[popq_reg] == FAW'(FIFO_DEPTH - 1))
            begin
                head_next[popq_reg] = '0;
            end
            else
            begin
                head_next[popq_reg] = head_reg[popq_reg] + 1'b1;
            end
            cnt_next[popq_reg] = cnt_reg[popq_reg] - 1'b1;
            total_next         = total_reg - 1'b1;
        end

        if (cmd.emit)
        begin
            ov_next                  = 1'b1;
            oitem_next.granted       = res_gnt_reg;
            oitem_next.grant_id      = res_id_reg;
            oitem_next.from_deferred = res_def_reg;
            oitem_next.status        = res_st_reg;
            oitem_next.pending_count = PEND_W'(total_reg);
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            req_reg   <= in_item.req_type;
            id_reg    <= in_item.task_id;
            prio_reg  <= prio_sat;
            now_reg   <= in_item.now;
            delay_reg <= in_item.delay;
        end
        popq_reg      <= popq_next;
        rd_idx_reg    <= rd_idx_next;
        best_idx_reg  <= best_idx_next;
        best_diff_reg <= best_diff_next;
        best_age_reg  <= best_age_next;
        best_id_reg   <= best_id_next;
        free_idx_reg  <= free_idx_next;
        res_gnt_reg   <= res_gnt_next;
        res_id_reg    <= res_id_next;
        res_def_reg   <= res_def_next;
        res_st_reg    <= res_st_next;
        oitem_reg     <= oitem_next;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg   <= MARGIN_RESET;
            head_reg     <= '{default: '0};
            cnt_reg      <= '{default: '0};
            total_reg    <= '0;
            valid_reg    <= '0;
            age_reg      <= '{default: '0};
            scan_act_reg <= 1'b0;
            issue_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            done_reg     <= 1'b0;
            best_fnd_reg <= 1'b0;
            free_fnd_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                margin_reg <= cfg_wdata;
            end
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            total_reg    <= total_next;
            valid_reg    <= valid_next;
            age_reg      <= age_next;
            scan_act_reg <= scan_act_next;
            issue_reg    <= issue_next;
            rd_vld_reg   <= rd_vld_next;
            done_reg     <= done_next;
            best_fnd_reg <= best_fnd_next;
            free_fnd_reg <= free_fnd_next;
            ov_reg       <= ov_next;
        end
    end

endmodule

// File: src/priority_task_scheduler_with_timed_retry_core.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_with_timed_retry_core
// Strict-priority task scheduler with a timed retry list.
// ----------------------------------------------------------------------------
// The scheduler takes one transaction at a time. A submit reaches the result
// register from the submit state. A defer or next request walks the deferred
// list one entry per cycle through the list memory's read port, then passes
// the decide state; a next request that pops a priority FIFO then reads the
// FIFO memory in the FIFO read state. A request code of 3 goes to the emit
// state. The result sits in an output register, so a new transaction is
// taken while the previous result still waits for out_ready. The due margin
// register may be written whenever the block is idle and takes effect on the
// next request. pending_count reports the low 7 bits of the total FIFO fill.
// ----------------------------------------------------------------------------
module priority_task_scheduler_with_timed_retry_core #(
    parameter int NUM_PRIORITIES = pts_pkg::NUM_PRIORITIES_DEF,
    parameter int FIFO_DEPTH     = pts_pkg::FIFO_DEPTH_DEF,
    parameter int DEFERRED_DEPTH = pts_pkg::DEFERRED_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pts_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pts_pkg::out_item_t            out_item,
    input  logic                          cfg_we,
    input  logic [pts_pkg::MARGIN_W-1:0]  cfg_wdata
);
    import pts_pkg::*;

    // Command and status records between the sequencer and the datapath.
    cmd_t  cmd;
    stat_t stat;

    // The sequencer owns the transaction flow: it accepts a transaction,
    // starts the deferred list walk, lets the datapath decide and emit.
    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (in_item.req_type),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the FIFOs, the deferred list and the output stage.
    pts_dp #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .FIFO_DEPTH     (FIFO_DEPTH),
        .DEFERRED_DEPTH (DEFERRED_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// File: src/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input pts_pkg::out_item_t            out_item
);
    import pts_pkg::*;

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Without a grant the id and source flag read zero.
    a_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.granted |->
            (out_item.grant_id == '0) && !out_item.from_deferred)
        else $error("ungranted result carries an id");

    // A deferred grant is always a successful grant.
    a_def_grant: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.from_deferred |->
            out_item.granted && (out_item.status == ST_OK))
        else $error("deferred grant with bad status");

    // One transaction at a time: after acceptance the input closes.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

endmodule

bind priority_task_scheduler_with_timed_retry_core pts_checker u_pts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
